[hdl/sfda_pkg.sv]
// Shared types and constants for the signed fixed-width decimal ASCII formatter.
// No dependencies.
package sfda_pkg;

  localparam int unsigned MaxDigitsDef = 5;
  localparam int unsigned DigitCountRst = 5;
  localparam int unsigned PaddrW = 2;

  localparam logic [6:0] CharMinus = 7'd45;
  localparam logic [6:0] CharZero  = 7'd48;

  // floor(m / 10) == (m * Recip10) >> Recip10Shift for every 32-bit m
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift = 35;

  typedef struct packed {
    logic       neg;
    logic [2:0] n;
  } item_ctl_t;

endpackage

[hdl/sfda_digit_stage.sv]
// One pipeline stage: divides the running magnitude by ten and keeps the remainder digit.
// Depends on sfda_pkg.
module sfda_digit_stage import sfda_pkg::*; #(
  parameter int unsigned MaxDigits = MaxDigitsDef,
  parameter int unsigned Idx = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [31:0]                mag_i,
  input  logic [MaxDigits-1:0][3:0]  digits_i,
  input  item_ctl_t                  ctl_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [31:0]                mag_o,
  output logic [MaxDigits-1:0][3:0]  digits_o,
  output item_ctl_t                  ctl_o
);

  logic                      valid_q;
  logic [31:0]               mag_q;
  logic [MaxDigits-1:0][3:0] digits_q, digits_d;
  item_ctl_t                 ctl_q;
  logic [63:0]               prod;
  logic [31:0]               quot;
  logic [31:0]               rem;
  logic                      load;

  assign prod = {32'd0, mag_i} * {32'd0, Recip10};
  assign quot = 32'(prod[63:Recip10Shift]);
  assign rem  = mag_i - {quot[28:0], 3'b000} - {quot[30:0], 1'b0};

  always_comb begin
    digits_d      = digits_i;
    digits_d[Idx] = rem[3:0];
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mag_q    <= quot;
      digits_q <= digits_d;
      ctl_q    <= ctl_i;
    end
  end

  assign out_valid_o = valid_q;
  assign mag_o       = mag_q;
  assign digits_o    = digits_q;
  assign ctl_o       = ctl_q;

endmodule

[hdl/sfda_serialiser.sv]
// Holds one formatted value and sends it out one character per transaction.
// Depends on sfda_pkg.
module sfda_serialiser import sfda_pkg::*; #(
  parameter int unsigned MaxDigits = MaxDigitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [MaxDigits-1:0][3:0] digits_i,
  input  item_ctl_t                 ctl_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [6:0]                ascii_char_o,
  output logic                      last_char_o
);

  localparam int unsigned IdxW = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;

  logic                      hold_valid_q;
  logic                      sign_q;
  logic [2:0]                cnt_q;
  logic [MaxDigits-1:0][3:0] digits_q;
  logic [3:0]                idx;
  logic [3:0]                cur_digit;
  logic                      last;
  logic                      fire;
  logic                      load;

  assign idx       = {1'b0, cnt_q - 3'd1};
  assign cur_digit = digits_q[idx[IdxW-1:0]];
  assign last      = !sign_q && (cnt_q == 3'd1);
  assign fire      = hold_valid_q && !out_stall_i;
  assign in_ready_o = !hold_valid_q || (fire && last);
  assign load      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      sign_q       <= 1'b0;
      cnt_q        <= 3'd0;
    end else if (load) begin
      hold_valid_q <= 1'b1;
      sign_q       <= ctl_i.neg;
      cnt_q        <= ctl_i.n;
    end else if (fire) begin
      if (sign_q) begin
        sign_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 3'd1;
      end
      if (last) begin
        hold_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      digits_q <= digits_i;
    end
  end

  assign out_valid_o  = hold_valid_q;
  assign ascii_char_o = sign_q ? CharMinus : (CharZero + {3'b000, cur_digit});
  assign last_char_o  = last;

  a_cnt_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> (cnt_q != 3'd0) && (32'(cnt_q) <= MaxDigits))
    else $error("serialiser digit count out of range");

  a_digit_decimal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && !sign_q) |-> (cur_digit < 4'd10))
    else $error("serialiser digit not decimal");

  a_empty_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last && !in_valid_i) |=> !hold_valid_q)
    else $error("value not released after its last character");

  a_sign_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && sign_q && !last) |=> (hold_valid_q && !sign_q && $stable(cnt_q)))
    else $error("digits did not follow the minus sign");

endmodule

[hdl/signed_fixed_width_decimal_ascii.sv]
// Signed 32-bit integer to fixed-width ASCII decimal text, one character per output
// transaction: an optional '-' then digit_count digits (1..MAX_DIGITS, leading zeros
// kept) of the magnitude modulo 10^digit_count, the final character flagged by
// last_char_o. A new value can enter every cycle while in_stall_o is low; the pipeline is an
// input stage, MAX_DIGITS divide-by-ten stages and an output holding register. The output
// serialiser sets the sustained rate: it sends n characters per value, n + 1 for a negative
// one, with n the effective digit count (at most 6 characters with the default of 5 digits),
// and it takes the next value as the last character of the current one goes out.
// Depends on sfda_pkg, sfda_digit_stage and sfda_serialiser.
module signed_fixed_width_decimal_ascii import sfda_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MaxDigitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [6:0]        ascii_char_o,
  output logic              last_char_o
);

  logic [2:0]  digit_count_q;
  logic [2:0]  n_eff;
  logic        s0_valid_q;
  logic        s0_ready;
  logic [31:0] s0_mag_q;
  item_ctl_t   s0_ctl_q;
  item_ctl_t   s0_ctl_d;

  logic                       valid_w  [MAX_DIGITS+1];
  logic                       ready_w  [MAX_DIGITS+1];
  logic [31:0]                mag_w    [MAX_DIGITS+1];
  logic [MAX_DIGITS-1:0][3:0] digits_w [MAX_DIGITS+1];
  item_ctl_t                  ctl_w    [MAX_DIGITS+1];

  // register file: the single register sits at byte address 0
  assign pready = 1'b1;
  assign prdata = {29'd0, digit_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= 3'(DigitCountRst);
    end else if (psel && penable && pwrite && pready && (paddr == '0)) begin
      digit_count_q <= pwdata[2:0];
    end
  end

  always_comb begin
    if (digit_count_q == 3'd0) begin
      n_eff = 3'd1;
    end else if (32'(digit_count_q) > MAX_DIGITS) begin
      n_eff = 3'(MAX_DIGITS);
    end else begin
      n_eff = digit_count_q;
    end
  end

  // input stage: sign and unsigned magnitude
  assign s0_ctl_d.neg = value_i[31];
  assign s0_ctl_d.n   = n_eff;
  assign s0_ready     = !s0_valid_q || ready_w[0];
  assign in_stall_o   = !s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s0_ready) begin
      s0_mag_q <= value_i[31] ? (32'd0 - value_i) : value_i;
      s0_ctl_q <= s0_ctl_d;
    end
  end

  assign valid_w[0]  = s0_valid_q;
  assign mag_w[0]    = s0_mag_q;
  assign digits_w[0] = '0;
  assign ctl_w[0]    = s0_ctl_q;

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_digit
    sfda_digit_stage #(
      .MaxDigits (MAX_DIGITS),
      .Idx       (k)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_w[k]),
      .in_ready_o  (ready_w[k]),
      .mag_i       (mag_w[k]),
      .digits_i    (digits_w[k]),
      .ctl_i       (ctl_w[k]),
      .out_valid_o (valid_w[k+1]),
      .out_ready_i (ready_w[k+1]),
      .mag_o       (mag_w[k+1]),
      .digits_o    (digits_w[k+1]),
      .ctl_o       (ctl_w[k+1])
    );
  end

  sfda_serialiser #(
    .MaxDigits (MAX_DIGITS)
  ) u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid_w[MAX_DIGITS]),
    .in_ready_o   (ready_w[MAX_DIGITS]),
    .digits_i     (digits_w[MAX_DIGITS]),
    .ctl_i        (ctl_w[MAX_DIGITS]),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

endmodule
